>>> hw/rtl/pit_pkg.sv
// shared constants and widths for the point-in-triangle test
package pit_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  localparam int unsigned ProdWidth  = 2 * DiffWidth;
  localparam int unsigned CrossWidth = ProdWidth + 1;
  localparam int unsigned SumWidth   = CrossWidth + 2;

  localparam int unsigned InDataWidth  = ((2 * CoordWidth + 7) / 8) * 8;
  localparam int unsigned OutDataWidth = 8;

  localparam int unsigned NumRegs  = 6;
  localparam int unsigned CfgIdxW  = $clog2(NumRegs);

  localparam logic [CfgIdxW-1:0] RegAX = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegAY = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegBX = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegBY = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegCX = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegCY = CfgIdxW'(5);

  localparam int unsigned InsideBit     = 0;
  localparam int unsigned DegenerateBit = 1;

endpackage

>>> hw/rtl/point_in_triangle_test.sv
// point-in-triangle test, five-stage pipeline
//
// usage:
//   the triangle vertices a, b and c sit in six config registers written
//   through cfg_we_i / cfg_idx_i / cfg_wdata_i (0 ax, 1 ay, 2 bx, 3 by,
//   4 cx, 5 cy); writes to other indexes are dropped. write them only
//   while the pipeline is empty.
//   each input word carries one point (x low, y high). each point gives
//   one output word: bit 0 inside, bit 1 degenerate (zero-area triangle,
//   inside then reads 0). points on edges ab, ac and on vertex a count as
//   inside, points on edge bc (vertices b and c too) count as outside.
//   the stages are: offsets, six 17x17 multipliers, cross differences,
//   sign fold, final add and compare. one point is accepted every cycle
//   unless the receiver stalls.
//   reset clears all vertices to zero and empties the pipeline.
//   when the receiver stalls the whole pipeline holds; s_axis_tready
//   drops only while a finished word waits and is not taken, so nothing
//   is lost or repeated.
module point_in_triangle_test (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pit_pkg::InDataWidth-1:0]     s_axis_tdata,  // point_x, point_y
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pit_pkg::OutDataWidth-1:0]    m_axis_tdata,  // inside_res, degenerate
  input  logic                                cfg_we_i,
  input  logic [pit_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pit_pkg::CoordWidth-1:0]      cfg_wdata_i
);

  localparam int unsigned CW = pit_pkg::CoordWidth;
  localparam int unsigned DW = pit_pkg::DiffWidth;
  localparam int unsigned PW = pit_pkg::ProdWidth;
  localparam int unsigned XW = pit_pkg::CrossWidth;
  localparam int unsigned SW = pit_pkg::SumWidth;

  // vertex registers
  logic [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0;
      ay_q <= '0;
      bx_q <= '0;
      by_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pit_pkg::RegAX: ax_q <= cfg_wdata_i;
        pit_pkg::RegAY: ay_q <= cfg_wdata_i;
        pit_pkg::RegBX: bx_q <= cfg_wdata_i;
        pit_pkg::RegBY: by_q <= cfg_wdata_i;
        pit_pkg::RegCX: cx_q <= cfg_wdata_i;
        pit_pkg::RegCY: cy_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline enable
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign adv           = !v5_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage 1: offsets from vertex a
  logic [CW-1:0] px, py;
  logic signed [DW-1:0] e0x_d, e0y_d, e1x_d, e1y_d, dx_d, dy_d;
  logic signed [DW-1:0] e0x_q, e0y_q, e1x_q, e1y_q, dx_q, dy_q;

  assign px = s_axis_tdata[CW-1:0];
  assign py = s_axis_tdata[2*CW-1:CW];

  assign e0x_d = $signed({cx_q[CW-1], cx_q}) - $signed({ax_q[CW-1], ax_q});
  assign e0y_d = $signed({cy_q[CW-1], cy_q}) - $signed({ay_q[CW-1], ay_q});
  assign e1x_d = $signed({bx_q[CW-1], bx_q}) - $signed({ax_q[CW-1], ax_q});
  assign e1y_d = $signed({by_q[CW-1], by_q}) - $signed({ay_q[CW-1], ay_q});
  assign dx_d  = $signed({px[CW-1], px})     - $signed({ax_q[CW-1], ax_q});
  assign dy_d  = $signed({py[CW-1], py})     - $signed({ay_q[CW-1], ay_q});

  // stage 2: products
  logic signed [PW-1:0] p_ke_d, p_kf_d, p_ua_d, p_ub_d, p_va_d, p_vb_d;
  logic signed [PW-1:0] p_ke_q, p_kf_q, p_ua_q, p_ub_q, p_va_q, p_vb_q;

  assign p_ke_d = PW'(e0x_q) * PW'(e1y_q);
  assign p_kf_d = PW'(e0y_q) * PW'(e1x_q);
  assign p_ua_d = PW'(dx_q)  * PW'(e1y_q);
  assign p_ub_d = PW'(dy_q)  * PW'(e1x_q);
  assign p_va_d = PW'(e0x_q) * PW'(dy_q);
  assign p_vb_d = PW'(e0y_q) * PW'(dx_q);

  // stage 3: cross products
  logic signed [XW-1:0] k_d, nu_d, nv_d;
  logic signed [XW-1:0] k_q, nu_q, nv_q;

  assign k_d  = XW'(p_ke_q) - XW'(p_kf_q);
  assign nu_d = XW'(p_ua_q) - XW'(p_ub_q);
  assign nv_d = XW'(p_va_q) - XW'(p_vb_q);

  // stage 4: fold sign of k into the numerators
  logic signed [XW-1:0] kf_d, nuf_d, nvf_d;
  logic signed [XW-1:0] kf_q, nuf_q, nvf_q;
  logic                 deg_d, deg_q, deg5_q, inside5_q;

  assign deg_d = (k_q == '0);

  always_comb begin
    if (k_q[XW-1]) begin
      kf_d  = -k_q;
      nuf_d = -nu_q;
      nvf_d = -nv_q;
    end else begin
      kf_d  = k_q;
      nuf_d = nu_q;
      nvf_d = nv_q;
    end
  end

  // stage 5: u >= 0, v >= 0, u + v < k
  logic signed [SW-1:0] sum_d;
  logic                 inside_d;

  assign sum_d    = SW'(nuf_q) + SW'(nvf_q) - SW'(kf_q);
  assign inside_d = !deg_q && !nuf_q[XW-1] && !nvf_q[XW-1] && sum_d[SW-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e0x_q     <= e0x_d;
      e0y_q     <= e0y_d;
      e1x_q     <= e1x_d;
      e1y_q     <= e1y_d;
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      p_ke_q    <= p_ke_d;
      p_kf_q    <= p_kf_d;
      p_ua_q    <= p_ua_d;
      p_ub_q    <= p_ub_d;
      p_va_q    <= p_va_d;
      p_vb_q    <= p_vb_d;
      k_q       <= k_d;
      nu_q      <= nu_d;
      nv_q      <= nv_d;
      kf_q      <= kf_d;
      nuf_q     <= nuf_d;
      nvf_q     <= nvf_d;
      deg_q     <= deg_d;
      deg5_q    <= deg_q;
      inside5_q <= inside_d;
    end
  end

  always_comb begin
    m_axis_tdata                         = '0;
    m_axis_tdata[pit_pkg::InsideBit]     = inside5_q;
    m_axis_tdata[pit_pkg::DegenerateBit] = deg5_q;
  end

  assign m_axis_tvalid = v5_q;

endmodule

>>> hw/rtl/pit_checker.sv
// port-level checks for the point-in-triangle test
module pit_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pit_pkg::OutDataWidth-1:0] m_axis_tdata
);

  // a degenerate triangle never reports inside
  a_deg_not_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[pit_pkg::InsideBit] &&
                        m_axis_tdata[pit_pkg::DegenerateBit]))
    else $error("inside and degenerate both set");

  // input side stalls only while an output word waits
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // stalled output word stays and holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[pit_pkg::OutDataWidth-1:2] == '0))
    else $error("output padding not zero");

endmodule

bind point_in_triangle_test pit_checker u_pit_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_point_in_triangle_test.sv
// testbench for the point-in-triangle test: random points against an exact integer predictor
module tb_point_in_triangle_test;
  import pit_pkg::*;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [SumWidth-1:0]   acc_t;
  typedef struct packed {
    logic degenerate;
    logic hit;
  } verdict_t;

  localparam int unsigned Latency   = 5;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned MaxReport = 10;
  localparam int          CoordMin  = -(2 ** (CoordWidth - 1));
  localparam int          CoordMax  = 2 ** (CoordWidth - 1) - 1;

  localparam logic [CfgIdxW-1:0] RegOrder [NumRegs] = '{RegAX, RegAY, RegBX, RegBY, RegCX, RegCY};
  localparam logic [CfgIdxW-1:0] BadIdxLo = CfgIdxW'(NumRegs);
  localparam logic [CfgIdxW-1:0] BadIdxHi = CfgIdxW'(NumRegs + 1);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_valid = 1'b0;
  logic                    s_ready;
  logic [InDataWidth-1:0]  s_data  = '0;  // point_x, point_y
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [OutDataWidth-1:0] m_data;        // inside_res, degenerate
  logic                    cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx   = '0;
  logic [CoordWidth-1:0]   cfg_wdata = '0;

  coord_t                 vtx [NumRegs];
  logic [InDataWidth-1:0] points_to_send [$];
  verdict_t               verdicts_due [$];
  int unsigned            errors = 0;
  int unsigned            in_gap = 0;
  int unsigned            out_gap = 0;
  int unsigned            idle_cycles = 0;
  bit                     calm = 1'b0;

  point_in_triangle_test dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic verdict_t classify_point(coord_t px, coord_t py);
    acc_t e0x, e0y, e1x, e1y, dx, dy, area, nu, nv;
    verdict_t v;
    e0x = vtx[RegCX] - vtx[RegAX];
    e0y = vtx[RegCY] - vtx[RegAY];
    e1x = vtx[RegBX] - vtx[RegAX];
    e1y = vtx[RegBY] - vtx[RegAY];
    dx  = px - vtx[RegAX];
    dy  = py - vtx[RegAY];
    area = e0x * e1y - e0y * e1x;
    nu   = dx * e1y - dy * e1x;
    nv   = e0x * dy - e0y * dx;
    v = '0;
    if (area == 0) begin
      v.degenerate = 1'b1;
    end else begin
      if (area < 0) begin
        area = -area;
        nu   = -nu;
        nv   = -nv;
      end
      v.hit = (nu >= 0) && (nv >= 0) && ((nu + nv - area) < 0);
    end
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < CoordMin) return CoordMin;
    if (v > CoordMax) return CoordMax;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 2 ** CoordWidth - 1)) + CoordMin;
  endfunction

  function automatic int near(int c, int r);
    return clamp_coord(c - r + int'($urandom_range(0, 2 * r)));
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      in_gap = 0;
    end else begin
      if (s_valid && s_ready) begin
        verdicts_due.insert(verdicts_due.size(),
                            classify_point(s_data[CoordWidth-1:0],
                                           s_data[2*CoordWidth-1:CoordWidth]));
      end
      if (!s_valid || s_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          s_valid <= 1'b0;
        end else if (points_to_send.size() != 0) begin
          s_data  <= points_to_send.pop_front();
          s_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (m_valid && m_ready) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          if (errors <= MaxReport) begin
            $display("unexpected output word: inside %0b degenerate %0b",
                     m_data[InsideBit], m_data[DegenerateBit]);
          end
        end else begin
          want = verdicts_due.pop_front();
          if (m_data[InsideBit] !== want.hit ||
              m_data[DegenerateBit] !== want.degenerate) begin
            errors++;
            if (errors <= MaxReport) begin
              $display({"mismatch: got inside %0b degenerate %0b, ",
                        "expected inside %0b degenerate %0b"},
                       m_data[InsideBit], m_data[DegenerateBit], want.hit,
                       want.degenerate);
            end
          end
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb_point_in_triangle_test NOT OK");
        $finish;
      end
    end
  end

  task automatic push_point(int x, int y);
    coord_t cx, cy;
    cx = coord_t'(clamp_coord(x));
    cy = coord_t'(clamp_coord(y));
    points_to_send.insert(points_to_send.size(), {cy, cx});
  endtask

  task automatic set_triangle(int ax, int ay, int bx, int by, int cx, int cy);
    int vals [NumRegs];
    vals = '{ax, ay, bx, by, cx, cy};
    for (int i = 0; i < NumRegs; i++) begin
      @(posedge clk_i);
      cfg_we    <= 1'b1;
      cfg_idx   <= RegOrder[i];
      cfg_wdata <= coord_t'(clamp_coord(vals[i]));
      vtx[RegOrder[i]] = coord_t'(clamp_coord(vals[i]));
    end
    // out-of-range indexes must be dropped
    @(posedge clk_i);
    cfg_idx   <= BadIdxLo;
    cfg_wdata <= CoordWidth'($urandom);
    @(posedge clk_i);
    cfg_idx   <= BadIdxHi;
    cfg_wdata <= CoordWidth'($urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (points_to_send.size() != 0 || s_valid || verdicts_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (2 * Latency) @(posedge clk_i);
  endtask

  task automatic random_phase(int kind, int count);
    int vx [3];
    int vy [3];
    int lo_x, hi_x, lo_y, hi_y, c0, c1, r, sel, e;
    case (kind)
      0: begin
        c0 = rand_coord();
        c1 = rand_coord();
        r  = $urandom_range(1, 3000);
        for (int i = 0; i < 3; i++) begin
          vx[i] = near(c0, r);
          vy[i] = near(c1, r);
        end
      end
      1: begin
        for (int i = 0; i < 3; i++) begin
          vx[i] = rand_coord();
          vy[i] = rand_coord();
        end
      end
      2: begin
        vx[0] = rand_coord();
        vy[0] = rand_coord();
        vx[1] = near(vx[0], 1000);
        vy[1] = near(vy[0], 1000);
        if ($urandom_range(0, 1) == 0) begin
          vx[2] = vx[0];
          vy[2] = vy[0];
        end else begin
          vx[2] = clamp_coord(2 * vx[1] - vx[0]);
          vy[2] = clamp_coord(2 * vy[1] - vy[0]);
        end
      end
      3: begin
        for (int i = 0; i < 3; i++) begin
          sel = $urandom_range(0, 2);
          vx[i] = (sel == 0) ? CoordMin : (sel == 1) ? CoordMax : rand_coord();
          sel = $urandom_range(0, 2);
          vy[i] = (sel == 0) ? CoordMin : (sel == 1) ? CoordMax : rand_coord();
        end
      end
      default: begin
        vx[0] = rand_coord();
        vy[0] = rand_coord();
        vx[1] = near(vx[0], 2000);
        vy[1] = near(vy[0], 2000);
        vx[2] = near(vx[1], 1);
        vy[2] = near(vy[1], 1);
      end
    endcase
    set_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
    lo_x = clamp_coord(((vx[0] < vx[1] ? vx[0] : vx[1]) < vx[2] ?
                        (vx[0] < vx[1] ? vx[0] : vx[1]) : vx[2]) - 2);
    hi_x = clamp_coord(((vx[0] > vx[1] ? vx[0] : vx[1]) > vx[2] ?
                        (vx[0] > vx[1] ? vx[0] : vx[1]) : vx[2]) + 2);
    lo_y = clamp_coord(((vy[0] < vy[1] ? vy[0] : vy[1]) < vy[2] ?
                        (vy[0] < vy[1] ? vy[0] : vy[1]) : vy[2]) - 2);
    hi_y = clamp_coord(((vy[0] > vy[1] ? vy[0] : vy[1]) > vy[2] ?
                        (vy[0] > vy[1] ? vy[0] : vy[1]) : vy[2]) + 2);
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        push_point(lo_x + int'($urandom_range(0, hi_x - lo_x)),
                   lo_y + int'($urandom_range(0, hi_y - lo_y)));
      end else if (sel < 75) begin
        e = $urandom_range(0, 2);
        push_point(vx[e], vy[e]);
      end else if (sel < 85) begin
        e = $urandom_range(0, 2);
        push_point(((vx[e] + vx[(e + 1) % 3]) >>> 1) + int'($urandom_range(0, 2)) - 1,
                   ((vy[e] + vy[(e + 1) % 3]) >>> 1) + int'($urandom_range(0, 2)) - 1);
      end else begin
        push_point(rand_coord(), rand_coord());
      end
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) vtx[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all vertices zero after reset
    push_point(0, 0);
    push_point(CoordMax, CoordMin);
    wait_idle();

    // edges ab and ac inside, edge bc outside, field extremes
    set_triangle(0, 0, 1000, 0, 0, 1000);
    push_point(0, 0);
    push_point(1000, 0);
    push_point(0, 1000);
    push_point(500, 0);
    push_point(0, 500);
    push_point(500, 500);
    push_point(100, 100);
    push_point(CoordMin, CoordMin);
    push_point(CoordMax, CoordMax);
    push_point(CoordMin, CoordMax);
    push_point(CoordMax, CoordMin);
    wait_idle();

    // largest triangle
    set_triangle(CoordMin, CoordMin, CoordMax, CoordMin, CoordMin, CoordMax);
    push_point(CoordMin, CoordMin);
    push_point(CoordMax, CoordMin);
    push_point(CoordMin, CoordMax);
    push_point(-1, -1);
    wait_idle();

    // clockwise winding
    set_triangle(0, 0, 0, 1000, 1000, 0);
    push_point(0, 0);
    push_point(10, 10);
    push_point(600, 600);
    wait_idle();

    // collinear vertices
    set_triangle(0, 0, 10, 10, 20, 20);
    push_point(10, 10);
    push_point(5, 5);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      calm = (p == 3 || p == 7);
      random_phase(p % 5, 65);
    end
    calm = 1'b0;

    wait_idle();
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("tb_point_in_triangle_test OK");
    end else begin
      $display("tb_point_in_triangle_test NOT OK");
    end
    $finish;
  end

endmodule

>>> point_in_triangle_test.f
hw/rtl/pit_pkg.sv
hw/rtl/point_in_triangle_test.sv
hw/rtl/pit_checker.sv
tb/tb_point_in_triangle_test.sv
